[hw/rtl/mtkr_pkg.sv]
// Shared types, constants and float helpers for the top-k router.
`timescale 1ns / 1ps
`default_nettype none
package mtkr_pkg;
  localparam int MaxExperts = 1024;
  localparam int MaxK = 8;
  localparam int IdxW = 10;
  localparam int CntW = 11;
  localparam int FillW = 4;
  localparam int KselW = 3;
  localparam int QDepth = 4;
  localparam int QPtrW = 2;
  localparam logic [31:0] LogitFloor = 32'hF149F2CA; // -1e30f

  localparam logic [2:0] AddrCutQ = 3'd0;
  localparam logic [2:0] AddrCutH = 3'd1;
  localparam logic [2:0] AddrCutT = 3'd2;
  localparam logic [2:0] AddrTopK = 3'd3;

  // request queued from front to back
  typedef struct packed {
    logic [31:0]     logit;
    logic [IdxW-1:0] index;
    logic            rank;   // logit takes part in ranking
    logic            last;
    logic            ovf;    // request overflowed
    logic [1:0]      width;
  } mtkr_req_t;

  typedef enum logic [1:0] {
    BK_RUN  = 2'd0,
    BK_EMIT = 2'd1
  } mtkr_bk_state_t;

  function automatic logic is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  // a < b for non-NaN binary32 values, signed zeros equal
  function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
    logic az, bz;
    az = (a[30:0] == 31'd0);
    bz = (b[30:0] == 31'd0);
    if (az && bz) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (a[31]) return a[30:0] > b[30:0];
    return a[30:0] < b[30:0];
  endfunction
endpackage
`default_nettype wire

[hw/rtl/moe_top_k_router_width_gate_core.sv]
// Top level of the mixture-of-experts top-k router with width gate.
// Input stream: one binary32 logit per expert, tuser carries sigma, tlast
//   closes the routing request. A four-entry queue decouples intake from
//   ranking in the back end, so logits stream at one per cycle while rows
//   are not being emitted and no stalled row holds the back end.
// On the last logit the back end emits min(top_k clamped to 1..8, kept)
//   rows, one per cycle while the receiver takes them, via a single output
//   register, or one row marked not found / overflow. With an empty queue
//   the last logit passes the queue, the emit state and the output register.
// Output stream: tdata holds the row fields, tlast marks the final row.
//   A stalled receiver holds the output register; the queue then fills and
//   in_tready drops.
// Reset clears counters, the kept list fill and queue; cutoff and top_k
//   registers return to their defaults. The user must write registers over
//   APB only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module moe_top_k_router_width_gate_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // logit_bits
  input  wire logic [31:0] in_tuser,   // sigma_bits
  input  wire logic        in_tlast,   // last_expert
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // expert_index, score_bits, width_code,
                                       // found, selected_count, status, pad
  output logic             out_tlast,  // last_row
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [30:0] cq_r, ch_r, ct_r;
  logic [3:0] tk_r;
  logic wr;
  logic q_full, q_push, q_pop, q_ne;
  mtkr_pkg::mtkr_req_t q_wd, q_rd;
  logic [mtkr_pkg::IdxW-1:0] o_index;
  logic [31:0] o_score;
  logic [1:0] o_width;
  logic o_found, o_status;
  logic [3:0] o_count;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cq_r <= 31'd1041865114;
      ch_r <= 31'd1050253722;
      ct_r <= 31'd1056964608;
      tk_r <= 4'd1;
    end else if (wr) begin
      priority case (cfg_paddr[3:2])
        mtkr_pkg::AddrCutQ[1:0]: cq_r <= cfg_pwdata[30:0];
        mtkr_pkg::AddrCutH[1:0]: ch_r <= cfg_pwdata[30:0];
        mtkr_pkg::AddrCutT[1:0]: ct_r <= cfg_pwdata[30:0];
        mtkr_pkg::AddrTopK[1:0]: tk_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      mtkr_pkg::AddrCutQ[1:0]: cfg_prdata = {1'b0, cq_r};
      mtkr_pkg::AddrCutH[1:0]: cfg_prdata = {1'b0, ch_r};
      mtkr_pkg::AddrCutT[1:0]: cfg_prdata = {1'b0, ct_r};
      default:                 cfg_prdata = {28'd0, tk_r};
    endcase
  end

  mtkr_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .logit(in_tdata), .sigma(in_tuser), .last(in_tlast),
    .cut_q(cq_r), .cut_h(ch_r), .cut_t(ct_r),
    .q_full, .q_push, .q_data(q_wd)
  );

  mtkr_queue u_queue (
    .clk, .rst_n, .push(q_push), .wdata(q_wd), .full(q_full),
    .pop(q_pop), .nempty(q_ne), .rdata(q_rd)
  );

  mtkr_back u_back (
    .clk, .rst_n, .q_nempty(q_ne), .q_data(q_rd), .q_pop,
    .top_k(tk_r), .out_valid(out_tvalid), .out_ready(out_tready),
    .o_index, .o_score, .o_width, .o_found, .o_count, .o_status,
    .o_last(out_tlast)
  );

  assign out_tdata = {6'd0, o_status, o_count, o_found, o_width, o_score, o_index};
endmodule
`default_nettype wire

[hw/rtl/mtkr_front.sv]
// Front end: counts experts, qualifies logits, tags each item with a width code (the back end keeps the last item's).
`timescale 1ns / 1ps
`default_nettype none
module mtkr_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [31:0]          logit,
  input  wire logic [31:0]          sigma,
  input  wire logic                 last,
  input  wire logic [30:0]          cut_q,
  input  wire logic [30:0]          cut_h,
  input  wire logic [30:0]          cut_t,
  input  wire logic                 q_full,
  output logic                      q_push,
  output mtkr_pkg::mtkr_req_t       q_data
);
  logic [mtkr_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic ovf_r, ovf_nxt;
  logic in_range, ovf_now;
  logic [1:0] w;

  always_comb begin
    logic [31:0] s;
    s = sigma;
    if (mtkr_pkg::is_nan(s) || (s[31] && s[30:0] != 31'd0)) w = 2'd3;
    else if (!mtkr_pkg::is_nan({1'b0, cut_q}) && mtkr_pkg::f_lt(s, {1'b0, cut_q})) w = 2'd0;
    else if (!mtkr_pkg::is_nan({1'b0, cut_h}) && mtkr_pkg::f_lt(s, {1'b0, cut_h})) w = 2'd1;
    else if (!mtkr_pkg::is_nan({1'b0, cut_t}) && mtkr_pkg::f_lt(s, {1'b0, cut_t})) w = 2'd2;
    else w = 2'd3;
  end

  assign in_ready = !q_full;
  assign q_push = in_valid && in_ready;
  assign in_range = (cnt_r < mtkr_pkg::CntW'(mtkr_pkg::MaxExperts));
  assign ovf_now = ovf_r || !in_range;

  always_comb begin
    q_data.logit = logit;
    q_data.index = cnt_r[mtkr_pkg::IdxW-1:0];
    q_data.rank  = in_range && !mtkr_pkg::is_nan(logit)
                   && mtkr_pkg::f_lt(mtkr_pkg::LogitFloor, logit);
    q_data.last  = last;
    q_data.ovf   = ovf_now;
    q_data.width = w;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (q_push) begin
      if (last) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        ovf_nxt = ovf_now;
        if (in_range) cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/mtkr_queue.sv]
// Short FIFO between front end and ranking back end.
`timescale 1ns / 1ps
`default_nettype none
module mtkr_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire mtkr_pkg::mtkr_req_t  wdata,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      nempty,
  output mtkr_pkg::mtkr_req_t       rdata
);
  mtkr_pkg::mtkr_req_t mem_r [mtkr_pkg::QDepth];
  logic [mtkr_pkg::QPtrW-1:0] wp_r, rp_r;
  logic [mtkr_pkg::QPtrW:0] cnt_r;

  assign full = (cnt_r == (mtkr_pkg::QPtrW+1)'(mtkr_pkg::QDepth));
  assign nempty = (cnt_r != '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (mtkr_pkg::QPtrW+1)'(push) - (mtkr_pkg::QPtrW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

[hw/rtl/mtkr_back.sv]
// Back end: sorted insertion into the kept list and result row emission.
`timescale 1ns / 1ps
`default_nettype none
module mtkr_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_nempty,
  input  wire mtkr_pkg::mtkr_req_t  q_data,
  output logic                      q_pop,
  input  wire logic [3:0]           top_k,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [mtkr_pkg::IdxW-1:0] o_index,
  output logic [31:0]               o_score,
  output logic [1:0]                o_width,
  output logic                      o_found,
  output logic [3:0]                o_count,
  output logic                      o_status,
  output logic                      o_last
);
  localparam int K = mtkr_pkg::MaxK;
  logic [31:0] ks_r [K];
  logic [mtkr_pkg::IdxW-1:0] ki_r [K];
  logic [mtkr_pkg::FillW-1:0] fill_r, fill_nxt;
  mtkr_pkg::mtkr_bk_state_t st_r, st_nxt;
  logic [mtkr_pkg::FillW-1:0] n_r, n_nxt, row_r, row_nxt;
  logic [1:0] w_r, w_nxt;
  logic ovf_r, ovf_nxt;
  logic ov_r, ov_nxt;
  logic [K-1:0] gt;
  logic [K-1:0] gt_prev;
  logic ins, do_item, adv;
  logic [mtkr_pkg::FillW-1:0] k_eff, n_now;

  always_comb begin
    for (int j = 0; j < K; j++)
      gt[j] = (mtkr_pkg::FillW'(j) < fill_r) && mtkr_pkg::f_lt(ks_r[j], q_data.logit);
  end

  // gt_prev[j] is gt[j-1], zero for the head slot
  assign gt_prev = {gt[K-2:0], 1'b0};

  assign adv = !ov_r || out_ready;
  assign do_item = (st_r == mtkr_pkg::BK_RUN) && q_nempty && adv;
  assign q_pop = do_item;
  assign ins = do_item && q_data.rank && !q_data.ovf &&
               ((gt != '0) || (fill_r < mtkr_pkg::FillW'(K)));

  always_comb begin
    if (top_k == 4'd0) k_eff = 4'd1;
    else if (top_k > mtkr_pkg::FillW'(K)) k_eff = mtkr_pkg::FillW'(K);
    else k_eff = top_k;
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      for (int j = 0; j < K; j++) begin
        if (gt[j] && !gt_prev[j]) begin
          ks_r[j] <= q_data.logit;
          ki_r[j] <= q_data.index;
        end else if (gt_prev[j]) begin
          ks_r[j] <= ks_r[j-1];
          ki_r[j] <= ki_r[j-1];
        end else if (gt == '0 && mtkr_pkg::FillW'(j) == fill_r) begin
          ks_r[j] <= q_data.logit;
          ki_r[j] <= q_data.index;
        end
      end
    end
  end

  always_comb begin
    logic [mtkr_pkg::FillW-1:0] f2;
    f2 = (ins && fill_r < mtkr_pkg::FillW'(K)) ? fill_r + 1'b1 : fill_r;
    n_now = (f2 < k_eff) ? f2 : k_eff;
    st_nxt = st_r;
    fill_nxt = f2;
    n_nxt = n_r;
    row_nxt = row_r;
    w_nxt = w_r;
    ovf_nxt = ovf_r;
    ov_nxt = ov_r && !out_ready;
    unique case (st_r)
      mtkr_pkg::BK_RUN: begin
        if (do_item && q_data.last) begin
          st_nxt = mtkr_pkg::BK_EMIT;
          n_nxt = q_data.ovf ? '0 : n_now;
          ovf_nxt = q_data.ovf;
          w_nxt = q_data.ovf ? 2'd3 : q_data.width;
          row_nxt = '0;
        end
      end
      mtkr_pkg::BK_EMIT: begin
        if (adv) begin
          ov_nxt = 1'b1;
          row_nxt = row_r + 1'b1;
          if (row_r + 1'b1 >= n_r) begin
            st_nxt = mtkr_pkg::BK_RUN;
            fill_nxt = '0;
          end
        end
      end
      default: st_nxt = mtkr_pkg::BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == mtkr_pkg::BK_EMIT && adv) begin
      o_found  <= (n_r != '0);
      o_index  <= (n_r != '0) ? ki_r[row_r[mtkr_pkg::KselW-1:0]] : '0;
      o_score  <= (n_r != '0) ? ks_r[row_r[mtkr_pkg::KselW-1:0]] : '0;
      o_width  <= w_r;
      o_count  <= n_r;
      o_status <= ovf_r;
      o_last   <= (row_r + 1'b1 >= n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mtkr_pkg::BK_RUN;
      fill_r <= '0;
      n_r <= '0;
      row_r <= '0;
      w_r <= '0;
      ovf_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      fill_r <= fill_nxt;
      n_r <= n_nxt;
      row_r <= row_nxt;
      w_r <= w_nxt;
      ovf_r <= ovf_nxt;
      ov_r <= ov_nxt;
    end
  end
  assign out_valid = ov_r;
endmodule
`default_nettype wire

[hw/rtl/mtkr_checker.sv]
// Port-level checker for the router core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mtkr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        cfg_pready
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[44] |-> out_tdata[48:45] != 4'd0)
    else $error("found row with zero count");
  a_nf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[44] |-> out_tlast)
    else $error("not-found row not last");
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[49] |-> !out_tdata[44] && out_tdata[43:42] == 2'd3)
    else $error("overflow row malformed");
  a_ready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");
endmodule

bind moe_top_k_router_width_gate_core mtkr_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tlast, .cfg_pready
);
`default_nettype wire
